FILE: src/stable_priority_task_queue_top_macros.svh
// ----------------------------------------------------------------------------
// stable priority task queue assertion macros
// concurrent checks, compiled away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SPQ_ASSERT_SAME(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("spq check failed");
// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("spq check failed");
`else
`define SPQ_ASSERT_SAME(label, clk, rst, lhs, rhs)
`define SPQ_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants, word types and sequencer codes of the task queue
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 16;

   localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_BITS   = 8;
   localparam int PREQ_BITS = 16;
   localparam int OCC_BITS  = 5;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [ID_BITS-1:0]   task_id;
      logic [PREQ_BITS-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0]  popped_id;
      logic                popped_valid;
      logic                dropped;
      logic [OCC_BITS-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [ID_BITS-1:0]       task_id;
   } slot_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] rd_idx;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_idx;
      logic                wr_new;
      slot_type            new_slot;
   } ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_POP
   } state_type;

endpackage

FILE: src/spq_slots.sv
// ----------------------------------------------------------------------------
// spq_slots
// slot register file with one read and one write port, plus the shared
// priority comparator used by the insert walk
// ----------------------------------------------------------------------------
module spq_slots (
   input  logic              clock,
   input  spq_pkg::ctrl_type ctrl,
   output spq_pkg::slot_type rd_slot,
   output logic              rd_gt
);
   import spq_pkg::*;

   slot_type slot_ff [QUEUE_DEPTH];
   slot_type slot_in;

   assign rd_slot = slot_ff[ctrl.rd_idx];
   // strictly greater: equal priorities stay ahead of the newcomer
   assign rd_gt   = rd_slot.prio > ctrl.new_slot.prio;
   assign slot_in = ctrl.wr_new ? ctrl.new_slot : rd_slot;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         slot_ff[ctrl.wr_idx] <= slot_in;
      end
   end

endmodule

FILE: src/spq_seq.sv
// ----------------------------------------------------------------------------
// spq_seq
// sequencer: walks the slots one per cycle for inserts and pops, keeps the
// entry count and registers the response word
// ----------------------------------------------------------------------------
module spq_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  spq_pkg::req_type  req_data,
   output logic              busy,
   input  spq_pkg::slot_type rd_slot,
   input  logic              rd_gt,
   output spq_pkg::ctrl_type ctrl,
   output logic              rsp_valid,
   output spq_pkg::rsp_type  rsp_data
);
   import spq_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] idx_dec;
   logic [CNT_BITS-1:0] count_inc;
   logic [CNT_BITS-1:0] count_dec;
   slot_type            new_ff, new_in;
   logic [ID_BITS-1:0]  popped_ff, popped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   assign idx_dec   = idx_ff - CNT_BITS'(1);
   assign count_inc = count_ff + CNT_BITS'(1);
   assign count_dec = count_ff - CNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      new_ff    <= new_in;
      popped_ff <= popped_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      new_in        = new_ff;
      popped_in     = popped_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ctrl.rd_idx   = '0;
      ctrl.wr_en    = 1'b0;
      ctrl.wr_idx   = '0;
      ctrl.wr_new   = 1'b0;
      ctrl.new_slot = new_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.mode == MODE_POP) begin
                  if (count_ff == '0) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.popped_id    = '0;
                     rsp_in.popped_valid = 1'b0;
                     rsp_in.dropped      = 1'b0;
                     rsp_in.occupancy    = OCC_BITS'(count_ff);
                  end else begin
                     // head is on the read port while idle
                     popped_in = rd_slot.task_id;
                     idx_in    = CNT_BITS'(1);
                     state_in  = ST_POP;
                  end
               end else begin
                  if (count_ff == CNT_BITS'(QUEUE_DEPTH)) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.popped_id    = '0;
                     rsp_in.popped_valid = 1'b0;
                     rsp_in.dropped      = 1'b1;
                     rsp_in.occupancy    = OCC_BITS'(count_ff);
                  end else begin
                     new_in.prio    = PRIORITY_BITS'(req_data.priority_req);
                     new_in.task_id = req_data.task_id;
                     idx_in         = count_ff;
                     state_in       = ST_INSERT;
                  end
               end
            end
         end
         ST_INSERT: begin
            // walk down from the tail, moving larger priorities up one slot
            ctrl.rd_idx = idx_dec[IDX_BITS-1:0];
            ctrl.wr_idx = idx_ff[IDX_BITS-1:0];
            ctrl.wr_en  = 1'b1;
            if (idx_ff == '0 || !rd_gt) begin
               ctrl.wr_new         = 1'b1;
               count_in            = count_inc;
               rsp_valid_in        = 1'b1;
               rsp_in.popped_id    = '0;
               rsp_in.popped_valid = 1'b0;
               rsp_in.dropped      = 1'b0;
               rsp_in.occupancy    = OCC_BITS'(count_inc);
               state_in            = ST_IDLE;
            end else begin
               idx_in = idx_dec;
            end
         end
         ST_POP: begin
            // close the gap at the head, one slot per cycle
            ctrl.rd_idx = idx_ff[IDX_BITS-1:0];
            ctrl.wr_idx = idx_dec[IDX_BITS-1:0];
            if (idx_ff >= count_ff) begin
               count_in            = count_dec;
               rsp_valid_in        = 1'b1;
               rsp_in.popped_id    = popped_ff;
               rsp_in.popped_valid = 1'b1;
               rsp_in.dropped      = 1'b0;
               rsp_in.occupancy    = OCC_BITS'(count_dec);
               state_in            = ST_IDLE;
            end else begin
               ctrl.wr_en = 1'b1;
               idx_in     = idx_ff + CNT_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/stable_priority_task_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_task_queue_top
// bounded task queue kept sorted by priority, stable for equal priorities
// ----------------------------------------------------------------------------
// usage:
//   a request word (mode, task_id, priority_req) is taken at a clock edge
//   with start high and busy low. mode insert places the task behind every
//   queued entry of smaller or equal priority; mode pop removes the head.
//   each request gives exactly one response word on rsp_data, shown for one
//   cycle with rsp_valid high; the receiver cannot stall it.
// operation:
//   insert into a full queue or pop of an empty queue: response in the cycle
//   after the request, busy stays low.
//   insert: the walk runs down from the tail past each entry of larger
//   priority. pop: the walk moves every entry behind the head up one slot.
//   the slot walk moves one entry per cycle through a single read and write
//   port and one priority comparator; busy is high during the walk and falls
//   with the response, so a new request may be taken while it is shown.
// reset:
//   synchronous, active high; the queue comes up empty, slot contents are
//   not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`include "stable_priority_task_queue_top_macros.svh"

module stable_priority_task_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  spq_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   ctrl_type ctrl;
   slot_type rd_slot;
   logic     rd_gt;

   spq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rd_slot   (rd_slot),
      .rd_gt     (rd_gt),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   spq_slots u_slots (
      .clock   (clock),
      .ctrl    (ctrl),
      .rd_slot (rd_slot),
      .rd_gt   (rd_gt)
   );

   `SPQ_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid)
   `SPQ_ASSERT_SAME(a_pop_drop_excl, clock, reset, rsp_valid, !(rsp_data.popped_valid && rsp_data.dropped))
   `SPQ_ASSERT_SAME(a_drop_when_full, clock, reset, rsp_valid && rsp_data.dropped, rsp_data.occupancy == OCC_BITS'(QUEUE_DEPTH))
   `SPQ_ASSERT_SAME(a_id_zero_no_pop, clock, reset, rsp_valid && !rsp_data.popped_valid, rsp_data.popped_id == '0)

endmodule
